// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// post must hold in the cycle after pre
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== src/tlc_pkg.sv =====
package tlc_pkg;

	// sizes
	localparam int LINE_MAX    = 512;
	localparam int ADDR_W      = $clog2(LINE_MAX);
	localparam int LEN_W       = $clog2(LINE_MAX + 1);
	localparam int TAB_STOP    = 8;
	localparam int TS_W        = $clog2(TAB_STOP);
	localparam int COL_W       = $clog2(LINE_MAX * TAB_STOP + 1);
	localparam int FORT_COLUMN = 72;
	localparam int CHAR_W      = 7;
	localparam int BYTE_W      = 8;
	localparam int LANES       = 8;
	localparam int LANE_W      = $clog2(LANES);
	localparam int CNT_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 1;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [COL_W-1:0]  col_t;

	// byte codes
	localparam byte_t CH_NUL   = 8'd0;
	localparam byte_t CH_BS    = 8'd8;
	localparam byte_t CH_TAB   = 8'd9;
	localparam byte_t CH_NL    = 8'd10;
	localparam byte_t CH_SPACE = 8'd32;
	localparam byte_t CH_TILDE = 8'd126;
	localparam byte_t CH_DEL   = 8'd127;

	localparam char_t CHR_TAB   = CH_TAB[CHAR_W-1:0];
	localparam char_t CHR_NL    = CH_NL[CHAR_W-1:0];
	localparam char_t CHR_SPACE = CH_SPACE[CHAR_W-1:0];

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORTRAN_MODE = 2'd0,
		REG_DROP_BLANK   = 2'd1
	} cfg_reg_t;

	// line sequencer
	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_READ,
		ST_PROC,
		ST_GAP,
		ST_NEWLINE
	} state_t;

	// character request from sequencer to packer
	typedef struct packed {
		logic  put;
		logic  fin;
		char_t ch;
	} emit_t;

	// next multiple of TAB_STOP strictly above col
	function automatic col_t next_stop(input col_t c);
		logic [COL_W-TS_W-1:0] hi;
		hi = c[COL_W-1:TS_W] + 1'b1;
		return {hi, {TS_W{1'b0}}};
	endfunction

endpackage

// ===== src/tlc_if.sv =====
// raw byte channel
interface tlc_byte_if;
	logic                      valid;
	logic                      ready;
	logic [tlc_pkg::BYTE_W-1:0] data_byte;
	logic                      end_of_input;

	modport source(output valid, output data_byte, output end_of_input, input ready);
	modport sink(input valid, input data_byte, input end_of_input, output ready);
endinterface

// packed output word channel
interface tlc_word_if;
	logic                      valid;
	logic                      ready;
	logic [tlc_pkg::CHAR_W-1:0] lane0;
	logic [tlc_pkg::CHAR_W-1:0] lane1;
	logic [tlc_pkg::CHAR_W-1:0] lane2;
	logic [tlc_pkg::CHAR_W-1:0] lane3;
	logic [tlc_pkg::CHAR_W-1:0] lane4;
	logic [tlc_pkg::CHAR_W-1:0] lane5;
	logic [tlc_pkg::CHAR_W-1:0] lane6;
	logic [tlc_pkg::CHAR_W-1:0] lane7;
	logic [tlc_pkg::CNT_W-1:0]  byte_count;
	logic                      last_of_line;

	modport source(output valid, output lane0, output lane1, output lane2, output lane3,
		output lane4, output lane5, output lane6, output lane7, output byte_count,
		output last_of_line, input ready);
	modport sink(input valid, input lane0, input lane1, input lane2, input lane3,
		input lane4, input lane5, input lane6, input lane7, input byte_count,
		input last_of_line, output ready);
endinterface

// ===== src/text_line_compactor_unit.sv =====
// Channel  Role    Payload
// -------  ------  ------------------------------------------------------
// bytes    sink    data_byte, end_of_input
// words    source  lane0..lane7, byte_count, last_of_line
// cfg      write   cfg_we, cfg_index, cfg_data (no read-back)
//
// Bytes are taken while a line collects; kept characters go to a 512 x 7 line store.
// When a line closes the sequencer walks the store through its single read port: a
// read state primes it, a process state takes each kept character, a gap state emits
// each re-encoded gap character and kept non-blank, then a newline state. No bytes are
// taken during that walk. The walk stalls when the held output word is not taken and
// the packer needs the output register: the next word is full, or the newline is due.
// Reset clears the control state; the line store is not cleared and needs no pass.
`include "assert_macros.svh"

module text_line_compactor_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	tlc_byte_if.sink                          bytes,
	tlc_word_if.source                        words,
	input  logic                              cfg_we,
	input  logic [tlc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tlc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	tlc_pkg::state_t               state_q, state_d;
	logic                          fort_cfg_q;
	logic                          drop_cfg_q;
	logic [tlc_pkg::LEN_W-1:0]     klen_q, klen_nx;
	logic [tlc_pkg::ADDR_W-1:0]    raw_q, raw_nx;
	logic                          nul_q, nul_nx;
	tlc_pkg::char_t                first_q, first_nx;
	logic                          dofort_q;
	logic [tlc_pkg::ADDR_W-1:0]    idx_q;
	logic [tlc_pkg::LEN_W-1:0]     next_idx;
	logic                          more;
	tlc_pkg::col_t                 col_q;
	tlc_pkg::col_t                 done_q;
	logic [tlc_pkg::LEN_W-1:0]     n_q;
	tlc_pkg::char_t                ch_q;

	logic                          acc;
	logic                          close_req;
	logic                          we;
	tlc_pkg::byte_t                b;
	logic [tlc_pkg::ADDR_W-1:0]    rd_addr;
	tlc_pkg::char_t                rdata;
	logic                          rd_blank;
	logic                          gap_open;
	logic                          gap_space;
	logic                          blank_drop;
	logic                          step;
	logic                          pk_ready;
	tlc_pkg::emit_t                emit;

	assign b        = bytes.data_byte;
	assign acc      = bytes.valid && bytes.ready;
	assign next_idx = {1'b0, idx_q} + tlc_pkg::LEN_W'(1);
	assign more     = next_idx < klen_q;
	assign rd_blank = (rdata == tlc_pkg::CHR_TAB) || (rdata == tlc_pkg::CHR_SPACE);
	assign gap_open = done_q < col_q;
	assign gap_space = (done_q[tlc_pkg::TS_W-1:0] == tlc_pkg::TS_W'(tlc_pkg::TAB_STOP - 1))
		|| (tlc_pkg::next_stop(done_q) > col_q);
	assign blank_drop = (n_q == '0) && drop_cfg_q;

	// effect of one request on the open line
	always_comb begin
		klen_nx   = klen_q;
		raw_nx    = raw_q;
		nul_nx    = nul_q;
		first_nx  = first_q;
		we        = 1'b0;
		close_req = 1'b0;
		if (bytes.end_of_input) begin
			close_req = raw_q != '0;
		end else begin
			raw_nx    = raw_q + 1'b1;
			close_req = (b == tlc_pkg::CH_NL)
				|| (raw_q >= tlc_pkg::ADDR_W'(tlc_pkg::LINE_MAX - 2));
			if (!nul_q) begin
				if (b == tlc_pkg::CH_NUL) begin
					nul_nx = 1'b1;
				end else if (b == tlc_pkg::CH_BS || b == tlc_pkg::CH_DEL) begin
					if (klen_q != '0) begin
						klen_nx = klen_q - 1'b1;
					end
				end else if (b == tlc_pkg::CH_TAB
						|| (b >= tlc_pkg::CH_SPACE && b <= tlc_pkg::CH_TILDE)) begin
					if (klen_q < tlc_pkg::LEN_W'(tlc_pkg::LINE_MAX)) begin
						we      = acc;
						klen_nx = klen_q + 1'b1;
						if (klen_q == '0) begin
							first_nx = b[tlc_pkg::CHAR_W-1:0];
						end
					end
				end else begin
					// other control and high bytes are dropped
				end
			end
		end
	end

	// sequencer outputs
	always_comb begin
		bytes.ready = 1'b0;
		emit        = '0;
		step        = 1'b0;
		rd_addr     = idx_q;
		case (state_q)
			tlc_pkg::ST_COLLECT: begin
				bytes.ready = 1'b1;
			end
			tlc_pkg::ST_READ: begin
				rd_addr = idx_q;
			end
			tlc_pkg::ST_PROC: begin
				rd_addr = next_idx[tlc_pkg::ADDR_W-1:0];
			end
			tlc_pkg::ST_GAP: begin
				rd_addr  = next_idx[tlc_pkg::ADDR_W-1:0];
				emit.put = n_q < tlc_pkg::LEN_W'(tlc_pkg::LINE_MAX);
				emit.ch  = gap_open ? (gap_space ? tlc_pkg::CHR_SPACE : tlc_pkg::CHR_TAB) : ch_q;
				step     = !emit.put || pk_ready;
			end
			tlc_pkg::ST_NEWLINE: begin
				emit.fin = !blank_drop;
				step     = !emit.fin || pk_ready;
			end
			default: begin
				bytes.ready = 1'b0;
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tlc_pkg::ST_COLLECT: begin
				if (acc && close_req) begin
					state_d = tlc_pkg::ST_READ;
				end
			end
			tlc_pkg::ST_READ: begin
				state_d = ({1'b0, idx_q} < klen_q) ? tlc_pkg::ST_PROC : tlc_pkg::ST_NEWLINE;
			end
			tlc_pkg::ST_PROC: begin
				if (rd_blank) begin
					state_d = more ? tlc_pkg::ST_PROC : tlc_pkg::ST_NEWLINE;
				end else if (dofort_q && col_q >= tlc_pkg::COL_W'(tlc_pkg::FORT_COLUMN)) begin
					state_d = tlc_pkg::ST_NEWLINE;
				end else begin
					state_d = tlc_pkg::ST_GAP;
				end
			end
			tlc_pkg::ST_GAP: begin
				if (step && !gap_open) begin
					state_d = more ? tlc_pkg::ST_PROC : tlc_pkg::ST_NEWLINE;
				end
			end
			tlc_pkg::ST_NEWLINE: begin
				if (step) begin
					state_d = tlc_pkg::ST_COLLECT;
				end
			end
			default: begin
				state_d = tlc_pkg::ST_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlc_pkg::ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fort_cfg_q <= 1'b0;
			drop_cfg_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tlc_pkg::REG_FORTRAN_MODE: fort_cfg_q <= cfg_data[0];
				tlc_pkg::REG_DROP_BLANK:   drop_cfg_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// line counters and walk datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q   <= '0;
			raw_q    <= '0;
			nul_q    <= 1'b0;
			idx_q    <= '0;
			col_q    <= '0;
			done_q   <= '0;
			n_q      <= '0;
			dofort_q <= 1'b0;
		end else begin
			case (state_q)
				tlc_pkg::ST_COLLECT: begin
					if (acc) begin
						klen_q <= klen_nx;
						raw_q  <= raw_nx;
						nul_q  <= nul_nx;
						if (close_req) begin
							idx_q    <= '0;
							col_q    <= '0;
							done_q   <= '0;
							n_q      <= '0;
							dofort_q <= fort_cfg_q
								&& (klen_nx == '0 || first_nx <= tlc_pkg::CHR_SPACE);
						end
					end
				end
				tlc_pkg::ST_PROC: begin
					if (rd_blank) begin
						col_q <= (rdata == tlc_pkg::CHR_TAB) ? tlc_pkg::next_stop(col_q)
							: col_q + 1'b1;
						if (more) begin
							idx_q <= next_idx[tlc_pkg::ADDR_W-1:0];
						end
					end
				end
				tlc_pkg::ST_GAP: begin
					if (step) begin
						n_q <= n_q + tlc_pkg::LEN_W'(emit.put);
						if (gap_open) begin
							done_q <= gap_space ? done_q + 1'b1 : tlc_pkg::next_stop(done_q);
						end else begin
							col_q  <= col_q + 1'b1;
							done_q <= col_q + 1'b1;
							if (more) begin
								idx_q <= next_idx[tlc_pkg::ADDR_W-1:0];
							end
						end
					end
				end
				tlc_pkg::ST_NEWLINE: begin
					if (step) begin
						klen_q <= '0;
						raw_q  <= '0;
						nul_q  <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// first kept character and held non-blank
	always_ff @(posedge clk) begin
		if (acc) begin
			first_q <= first_nx;
		end
		if (state_q == tlc_pkg::ST_PROC) begin
			ch_q <= rdata;
		end
	end

	tlc_ram #(
		.WIDTH(tlc_pkg::CHAR_W),
		.DEPTH(tlc_pkg::LINE_MAX)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (klen_q[tlc_pkg::ADDR_W-1:0]),
		.wdata   (b[tlc_pkg::CHAR_W-1:0]),
		.raddr   (rd_addr),
		.rdata_q (rdata)
	);

	tlc_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.emit       (emit),
		.emit_ready (pk_ready),
		.words      (words)
	);

	`ASSERT_ALWAYS(a_kept_le_raw, klen_q <= {1'b0, raw_q},
		"more kept characters than raw bytes")
	`ASSERT_ALWAYS(a_raw_limit, raw_q <= tlc_pkg::ADDR_W'(tlc_pkg::LINE_MAX - 1),
		"raw count past the line limit")
	`ASSERT_ALWAYS(a_proc_index, state_q != tlc_pkg::ST_PROC || {1'b0, idx_q} < klen_q,
		"walk reads past the kept length")
	`ASSERT_ALWAYS(a_gap_order, state_q != tlc_pkg::ST_GAP || done_q <= col_q,
		"gap emission ran past the target column")

endmodule

// ===== src/tlc_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module tlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

// ===== src/tlc_packer.sv =====
`include "assert_macros.svh"

// Packs characters into 8-lane words and holds one finished word for the sink.
module tlc_packer (
	input  logic                clk,
	input  logic                arst_n,
	input  tlc_pkg::emit_t      emit,
	output logic                emit_ready,
	tlc_word_if.source          words
);

	logic [tlc_pkg::LANES-1:0][tlc_pkg::CHAR_W-1:0] lane_q;
	logic [tlc_pkg::LANES-1:0][tlc_pkg::CHAR_W-1:0] lane_m;
	logic [tlc_pkg::LANES-1:0][tlc_pkg::CHAR_W-1:0] olane_q;
	logic [tlc_pkg::LANE_W-1:0]                    cnt_q;
	logic [tlc_pkg::CNT_W-1:0]                     ocnt_q;
	logic                                          olast_q;
	logic                                          ov_q;
	logic                                          out_free;
	logic                                          take;
	logic                                          push;

	// output register is free when empty or being taken
	assign out_free   = !ov_q || words.ready;
	assign emit_ready = emit.fin ? out_free : (!(&cnt_q) || out_free);
	assign take       = emit_ready && (emit.put || emit.fin);
	assign push       = take && (emit.fin || (&cnt_q));

	// merge the new character into the partial word
	always_comb begin
		lane_m        = lane_q;
		lane_m[cnt_q] = emit.fin ? tlc_pkg::CHR_NL : emit.ch;
	end

	// partial word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= '0;
			cnt_q  <= '0;
		end else if (take) begin
			if (push) begin
				lane_q <= '0;
				cnt_q  <= '0;
			end else begin
				lane_q <= lane_m;
				cnt_q  <= cnt_q + 1'b1;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (push) begin
			ov_q <= 1'b1;
		end else if (words.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			olane_q <= lane_m;
			ocnt_q  <= tlc_pkg::CNT_W'({1'b0, cnt_q}) + tlc_pkg::CNT_W'(1);
			olast_q <= emit.fin;
		end
	end

	assign words.valid        = ov_q;
	assign words.lane0        = olane_q[0];
	assign words.lane1        = olane_q[1];
	assign words.lane2        = olane_q[2];
	assign words.lane3        = olane_q[3];
	assign words.lane4        = olane_q[4];
	assign words.lane5        = olane_q[5];
	assign words.lane6        = olane_q[6];
	assign words.lane7        = olane_q[7];
	assign words.byte_count   = ocnt_q;
	assign words.last_of_line = olast_q;

	`ASSERT_NEXT(a_fin_clears, take && emit.fin, cnt_q == '0, "partial word not cleared after newline")
	`ASSERT_ALWAYS(a_cnt_range, !ov_q || (ocnt_q != '0 && ocnt_q <= tlc_pkg::CNT_W'(tlc_pkg::LANES)), "word lane count out of range")
	`ASSERT_ALWAYS(a_short_last, !ov_q || olast_q || ocnt_q == tlc_pkg::CNT_W'(tlc_pkg::LANES), "short word that is not the last of its line")

endmodule
